// ----- rtl/fdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the CRC-32 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam int          HDR_BYTES = 14;
    localparam int          MIN_BYTES = 18;
    localparam int          POS_W     = 17;

    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_FRAME_MAGIC = 1'b0;
    localparam logic [CFG_IW-1:0] REG_MAX_LEN     = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_OVERSIZED = 3'd3;
    localparam logic [2:0] ST_INCOMPL   = 3'd4;
    localparam logic [2:0] ST_CRC_BAD   = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic [2:0]  status_code;
        logic [7:0]  message_type;
        logic [7:0]  frame_flags;
        logic [31:0] sequence_number;
        logic [31:0] payload_length;
        logic [31:0] checksum;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        int          k;
        c = crc ^ {24'h0, b};
        for (k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/fdc_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_parser
// Per-byte frame parser: header decode, CRC-32 update, verdict and results.
// ----------------------------------------------------------------------------
module fdc_parser
    import fdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    output push_t             push
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next, upd_phase;
    logic [POS_W-1:0]   pos_reg, pos_next, upd_pos;
    logic [31:0]        shift_reg, shift_next, upd_shift;
    logic [31:0]        len_reg, len_next, upd_len;
    logic [7:0]         type_reg, type_next, upd_type;
    logic [7:0]         flags_reg, flags_next, upd_flags;
    logic [31:0]        seq_reg, seq_next, upd_seq;
    logic [31:0]        crc_reg, crc_next, upd_crc;
    logic [31:0]        rx_crc_reg, rx_crc_next, upd_rx_crc;
    logic               magic_bad_reg, magic_bad_next, upd_magic_bad;
    logic [31:0]        magic_reg;
    logic [15:0]        max_len_reg;

    logic               pay_en;
    logic               verdict;
    logic [2:0]         verdict_code;
    logic               eob_status;
    logic [2:0]         status_code;
    logic [POS_W-1:0]   len17;
    result_t            pay_res;
    result_t            stat_res;
    push_t              push_next;

    assign len17 = {1'b0, len_reg[15:0]};

    // state update for one byte
    always_comb
    begin
        upd_phase     = phase_reg;
        upd_pos       = pos_reg;
        upd_shift     = shift_reg;
        upd_len       = len_reg;
        upd_type      = type_reg;
        upd_flags     = flags_reg;
        upd_seq       = seq_reg;
        upd_crc       = crc_reg;
        upd_rx_crc    = rx_crc_reg;
        upd_magic_bad = magic_bad_reg;
        pay_en        = 1'b0;
        verdict       = 1'b0;
        verdict_code  = ST_OK;
        if (phase_reg != PH_DONE)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg < POS_W'(HDR_BYTES))
                    begin
                        upd_crc   = crc32_byte(crc_reg, data_byte);
                        upd_shift = {shift_reg[23:0], data_byte};
                        if (pos_reg == POS_W'(3))
                            upd_magic_bad = (upd_shift != magic_reg);
                        if (pos_reg == POS_W'(7))
                            upd_len = upd_shift;
                        if (pos_reg == POS_W'(8))
                            upd_type = data_byte;
                        if (pos_reg == POS_W'(9))
                            upd_flags = data_byte;
                        if (pos_reg == POS_W'(HDR_BYTES - 1))
                        begin
                            upd_seq = upd_shift;
                            if (!magic_bad_reg && (len_reg <= {16'h0, max_len_reg}))
                                upd_phase = (len_reg != 32'h0) ? PH_PAYLOAD : PH_TRAILER;
                        end
                    end
                    else if (pos_reg == POS_W'(MIN_BYTES - 1))
                    begin
                        verdict      = 1'b1;
                        verdict_code = magic_bad_reg ? ST_BAD_MAGIC : ST_OVERSIZED;
                        upd_phase    = PH_DONE;
                    end
                end
                PH_PAYLOAD:
                begin
                    upd_crc = crc32_byte(crc_reg, data_byte);
                    pay_en  = 1'b1;
                    if (pos_reg == POS_W'(HDR_BYTES - 1) + len17)
                        upd_phase = PH_TRAILER;
                end
                default:
                begin
                    upd_rx_crc = {rx_crc_reg[23:0], data_byte};
                    if (pos_reg == POS_W'(MIN_BYTES - 1) + len17)
                    begin
                        verdict      = 1'b1;
                        verdict_code = (~crc_reg == upd_rx_crc) ? ST_OK : ST_CRC_BAD;
                        upd_phase    = PH_DONE;
                    end
                end
            endcase
            upd_pos = pos_reg + POS_W'(1);
        end
    end

    // results and restart at end of buffer
    always_comb
    begin
        eob_status  = end_of_buffer && !verdict && (phase_reg != PH_DONE);
        status_code = verdict ? verdict_code
                    : ((pos_reg < POS_W'(MIN_BYTES - 1)) ? ST_TOO_SHORT : ST_INCOMPL);

        pay_res              = '0;
        pay_res.payload_byte = data_byte;
        pay_res.last_of_run  = !eob_status;

        stat_res                 = '0;
        stat_res.is_status       = 1'b1;
        stat_res.status_code     = status_code;
        stat_res.message_type    = upd_type;
        stat_res.frame_flags     = upd_flags;
        stat_res.sequence_number = upd_seq;
        stat_res.payload_length  = upd_len;
        stat_res.checksum        = ~upd_crc;
        stat_res.last_of_run     = 1'b1;

        push_next = '0;
        if (accept)
        begin
            if (pay_en)
            begin
                push_next.first = pay_res;
                push_next.second = stat_res;
                push_next.cnt = eob_status ? 2'd2 : 2'd1;
            end
            else if (verdict || eob_status)
            begin
                push_next.first = stat_res;
                push_next.cnt = 2'd1;
            end
        end

        phase_next     = upd_phase;
        pos_next       = upd_pos;
        shift_next     = upd_shift;
        len_next       = upd_len;
        type_next      = upd_type;
        flags_next     = upd_flags;
        seq_next       = upd_seq;
        crc_next       = upd_crc;
        rx_crc_next    = upd_rx_crc;
        magic_bad_next = upd_magic_bad;
        if (end_of_buffer)
        begin
            phase_next     = PH_HEADER;
            pos_next       = '0;
            shift_next     = '0;
            len_next       = '0;
            type_next      = '0;
            flags_next     = '0;
            seq_next       = '0;
            crc_next       = CRC_INIT;
            rx_crc_next    = '0;
            magic_bad_next = 1'b0;
        end
    end

    assign push = push_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            shift_reg     <= '0;
            len_reg       <= '0;
            type_reg      <= '0;
            flags_reg     <= '0;
            seq_reg       <= '0;
            crc_reg       <= CRC_INIT;
            rx_crc_reg    <= '0;
            magic_bad_reg <= 1'b0;
            magic_reg     <= '0;
            max_len_reg   <= 16'hFFFF;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                shift_reg     <= shift_next;
                len_reg       <= len_next;
                type_reg      <= type_next;
                flags_reg     <= flags_next;
                seq_reg       <= seq_next;
                crc_reg       <= crc_next;
                rx_crc_reg    <= rx_crc_next;
                magic_bad_reg <= magic_bad_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_MAGIC: magic_reg   <= cfg_data;
                    REG_MAX_LEN:     max_len_reg <= cfg_data[15:0];
                    default:         magic_reg   <= magic_reg;
                endcase
            end
        end
    end

    // two results only as payload beat followed by closing status
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> !push.first.is_status && !push.first.last_of_run
                             && push.second.is_status && push.second.last_of_run)
        else $error("bad two-result ordering");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> accept)
        else $error("result without accepted beat");

    a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_buffer |=> phase_reg == PH_HEADER && pos_reg == '0
                                    && crc_reg == CRC_INIT)
        else $error("parser not restarted after end of buffer");

endmodule

// ----- rtl/fdc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_queue
// Result queue: takes up to two results per cycle, delivers one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module fdc_queue
    import fdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    full_soon,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t          mem [QDEPTH];
    logic [QAW-1:0]   wr_reg, wr_next;
    logic [QAW-1:0]   rd_reg, rd_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign full_soon = (count_reg > QCW'(QDEPTH - 2));
    assign head      = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg + QAW'(push.cnt);
        rd_next    = rd_reg + QAW'(pop);
        count_next = count_reg + QCW'(push.cnt) - QCW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem[wr_reg + QAW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> count_reg <= QCW'(QDEPTH - 2))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.cnt == 2'd0 |=> count_reg == $past(count_reg) - QCW'(1))
        else $error("pop did not drain queue");

endmodule

// ----- rtl/frame_deframer_crc32_check_top.sv -----
`timescale 1ns / 1ps
// Each result beat is registered in the result queue and offered from its head.
// Throughput: one byte per cycle; a byte that ends a buffer mid-payload yields two beats,
// absorbed by the four-entry result queue, and input stalls while it holds three or more.
// Reset (rst_n low, async): parser restarts at header, magic reads 0, max length 65535,
// result queue empties.
// ----------------------------------------------------------------------------
// frame_deframer_crc32_check_top
// Length-prefixed frame parser with CRC-32 check and payload pass-through.
// ----------------------------------------------------------------------------
module frame_deframer_crc32_check_top
    import fdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              is_status,
    output logic [7:0]        payload_byte,
    output logic [2:0]        status_code,
    output logic [7:0]        message_type,
    output logic [7:0]        frame_flags,
    output logic [31:0]       sequence_number,
    output logic [31:0]       payload_length,
    output logic [31:0]       checksum,
    output logic              last_of_run
);

    push_t   push;
    result_t head;
    logic    full_soon;
    logic    accept;

    assign in_stall = full_soon;
    assign accept   = in_valid && !full_soon;

    fdc_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .push          (push)
    );

    fdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full_soon (full_soon),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign is_status       = head.is_status;
    assign payload_byte    = head.payload_byte;
    assign status_code     = head.status_code;
    assign message_type    = head.message_type;
    assign frame_flags     = head.frame_flags;
    assign sequence_number = head.sequence_number;
    assign payload_length  = head.payload_length;
    assign checksum        = head.checksum;
    assign last_of_run     = head.last_of_run;

endmodule
